// File: design/clng_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clng_pkg
// Shared types and constants for the cell-list neighbor grid.
// ----------------------------------------------------------------------------
package clng_pkg;

  // item modes
  localparam logic [2:0] MODE_DEPART = 3'd0;
  localparam logic [2:0] MODE_ARRIVE = 3'd1;
  localparam logic [2:0] MODE_ROW    = 3'd2;
  localparam logic [2:0] MODE_COL    = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_MAP_EN    = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_X  = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd2;
  localparam logic [2:0] CFG_CELL_EDGE = 3'd3;
  localparam logic [2:0] CFG_GRID_W    = 3'd4;
  localparam logic [2:0] CFG_GRID_H    = 3'd5;

  // configuration reset values and dimension bounds
  localparam logic [30:0] CELL_EDGE_RST = 31'd65536;
  localparam logic [6:0]  DIM_MAX       = 7'd64;
  localparam logic [6:0]  DIM_MIN       = 7'd1;

  // divider steps, one quotient bit each
  localparam int unsigned DIV_STEPS = 32;

  // last neighbor offset index along one axis
  localparam logic [1:0] NB_LAST = 2'd2;

  typedef enum logic [1:0] {
    AM_POINT = 2'd0,
    AM_ROW   = 2'd1,
    AM_COL   = 2'd2,
    AM_NEIGH = 2'd3
  } addr_mode_t;

  typedef struct packed {
    logic               map_en;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [30:0]        cell_edge;
    logic [6:0]         wdim;
    logic [6:0]         hdim;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       cap_x;
    logic       cap_y;
    addr_mode_t am;
    logic [6:0] k;
    logic [1:0] nx;
    logic [1:0] ny;
    logic       rd;
    logic       wr;
    logic       acc;
    logic       clr_wr;
    logic       out_load;
    logic       out_oor;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       en;
    logic [2:0] mode;
    logic       addr_ok;
    logic       last;
    logic       clr_last;
    logic       out_free;
  } ctrl_stat_t;

endpackage
`default_nettype wire

// File: design/clng_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clng_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module clng_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [32:0] dividend,
  input  wire logic [30:0]        divisor,
  output logic                    done,
  output logic [31:0]             quotient,
  output logic                    negative
);
  import clng_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [30:0]   rem;
  logic [31:0]   quo;
  logic [30:0]   dvs;
  logic          neg;

  logic signed [32:0] dvd_neg;
  logic [31:0]        mag;
  logic [31:0]        trial;
  logic               qbit;
  logic [31:0]        sub;
  logic [30:0]        rem_next;

  assign dvd_neg  = -dividend;
  assign mag      = dividend[32] ? dvd_neg[31:0] : dividend[31:0];
  assign trial    = {rem, quo[31]};
  assign qbit     = trial >= {1'b0, dvs};
  assign sub      = trial - {1'b0, dvs};
  assign rem_next = qbit ? sub[30:0] : trial[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= CW'(cnt + 1'b1);
        if (cnt == CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= mag;
      neg <= dividend[32];
      // zero edge counts as one
      dvs <= (divisor == '0) ? 31'd1 : divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[30:0], qbit};
    end
  end

  assign quotient = quo;
  assign negative = neg;

endmodule
`default_nettype wire

// File: design/clng_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clng_dp
// Datapath: item registers, cell coordinate divider, address generation,
// occupancy memory, neighbor accumulator and result register.
// ----------------------------------------------------------------------------
module clng_dp #(
  parameter int MAX_ACTORS = 64,
  parameter int GRID_CELLS = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire clng_pkg::cfg_t         cfg,
  input  wire clng_pkg::ctrl_cmd_t    cmd,
  output clng_pkg::ctrl_stat_t        stat,
  input  wire logic [2:0]             mode,
  input  wire logic [5:0]             actor_id,
  input  wire logic signed [31:0]     coord_x,
  input  wire logic signed [31:0]     coord_y,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [63:0]                 neighbor_mask,
  output logic                        out_of_range
);
  import clng_pkg::*;

  localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int MA = MAX_ACTORS;

  // item registers
  logic [2:0]         mode_q;
  logic [5:0]         actor_q;
  logic signed [32:0] dy_diff;

  // cell coordinates
  logic [5:0] cx;
  logic       cx_ok;
  logic [5:0] cy;
  logic       cy_ok;

  logic [MA-1:0] acc;
  logic [MA-1:0] mem_q;
  logic [MA-1:0] mem [GRID_CELLS];
  logic [AW-1:0] clr_cnt;

  logic signed [32:0] dx_diff;
  logic signed [32:0] div_dvd;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_q;
  logic               div_neg;

  logic [MA-1:0] bitv;
  logic [6:0]    col;
  logic [6:0]    row;
  logic          col_neg;
  logic          row_neg;
  logic          base_ok;
  logic          in_grid;
  logic [12:0]   lin;
  logic          lin_ok;
  logic          last;
  logic [AW-1:0] addr;
  logic [MA-1:0] wdata;
  logic          we;

  function automatic logic axis_ok(logic neg, logic [31:0] q, logic [6:0] dim);
    // negative offsets under one cell truncate to cell zero
    return !(neg && (q != '0)) && (q[31:7] == '0) && (q[6:0] < dim);
  endfunction

  assign dx_diff   = {coord_x[31], coord_x} - {cfg.origin_x[31], cfg.origin_x};
  assign div_start = cmd.load | cmd.cap_x;
  assign div_dvd   = cmd.load ? dx_diff : dy_diff;

  clng_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (cfg.cell_edge),
    .done     (div_done),
    .quotient (div_q),
    .negative (div_neg)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode;
      actor_q <= actor_id;
      dy_diff <= {coord_y[31], coord_y} - {cfg.origin_y[31], cfg.origin_y};
    end
    if (cmd.cap_x) begin
      cx    <= div_q[5:0];
      cx_ok <= axis_ok(div_neg, div_q, cfg.wdim);
    end
    if (cmd.cap_y) begin
      cy    <= div_q[5:0];
      cy_ok <= axis_ok(div_neg, div_q, cfg.hdim);
    end
  end

  // ids at or above the actor count shift out to an empty bit vector
  assign bitv = MA'(1) << actor_q;

  // column and row of the addressed cell, with a sign for neighbors left/above
  always_comb begin
    col     = '0;
    row     = '0;
    col_neg = 1'b0;
    row_neg = 1'b0;
    base_ok = 1'b0;
    last    = 1'b1;
    case (cmd.am)
      AM_POINT: begin
        col     = {1'b0, cx};
        row     = {1'b0, cy};
        base_ok = cx_ok & cy_ok;
        last    = 1'b1;
      end
      AM_ROW: begin
        col     = cmd.k;
        row     = {1'b0, cy};
        base_ok = cy_ok;
        last    = (cmd.k == 7'(cfg.wdim - 7'd1));
      end
      AM_COL: begin
        col     = {1'b0, cx};
        row     = cmd.k;
        base_ok = cx_ok;
        last    = (cmd.k == 7'(cfg.hdim - 7'd1));
      end
      AM_NEIGH: begin
        col     = 7'({1'b0, cx} + {5'b0, cmd.nx} - 7'd1);
        row     = 7'({1'b0, cy} + {5'b0, cmd.ny} - 7'd1);
        col_neg = (cx == '0) && (cmd.nx == '0);
        row_neg = (cy == '0) && (cmd.ny == '0);
        base_ok = cx_ok & cy_ok;
        last    = (cmd.nx == NB_LAST) && (cmd.ny == NB_LAST);
      end
      default: begin
        base_ok = 1'b0;
      end
    endcase
  end

  assign in_grid = base_ok && !col_neg && !row_neg && (col < cfg.wdim) && (row < cfg.hdim);
  assign lin     = 13'(13'(row[5:0]) * 13'(cfg.wdim)) + 13'(col[5:0]);
  assign lin_ok  = in_grid && (32'(lin) < 32'(GRID_CELLS));

  // occupancy memory, cleared by a sweep after reset
  assign addr  = cmd.clr_wr ? clr_cnt : AW'(lin);
  assign we    = cmd.clr_wr | cmd.wr;
  assign wdata = cmd.clr_wr ? '0 :
                 (mode_q == MODE_DEPART) ? (mem_q & ~bitv) : (mem_q | bitv);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= AW'(clr_cnt + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= '0;
    end else if (cmd.acc) begin
      acc <= acc | mem_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      neighbor_mask <= 64'(acc & ~bitv);
      out_of_range  <= cmd.out_oor;
    end
  end

  always_comb begin
    stat.div_done = div_done;
    stat.en       = cfg.map_en;
    stat.mode     = mode_q;
    stat.addr_ok  = lin_ok;
    stat.last     = last;
    stat.clr_last = (clr_cnt == AW'(GRID_CELLS - 1));
    stat.out_free = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

// File: design/clng_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clng_ctrl
// Sequencer: clearing sweep, coordinate division, cell walk and result.
// ----------------------------------------------------------------------------
module clng_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire clng_pkg::ctrl_stat_t stat,
  output clng_pkg::ctrl_cmd_t       cmd
);
  import clng_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_XDIV  = 9'b000000100,
    S_YDIV  = 9'b000001000,
    S_EVAL  = 9'b000010000,
    S_RD    = 9'b000100000,
    S_WR    = 9'b001000000,
    S_ACC   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [6:0] k;
  logic [6:0] k_next;
  logic [1:0] nx;
  logic [1:0] nx_next;
  logic [1:0] ny;
  logic [1:0] ny_next;
  logic       oor_flag;
  logic       oor_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      k        <= '0;
      nx       <= '0;
      ny       <= '0;
      oor_flag <= 1'b0;
    end else begin
      state    <= state_next;
      k        <= k_next;
      nx       <= nx_next;
      ny       <= ny_next;
      oor_flag <= oor_flag_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    state_next    = state;
    k_next        = k;
    nx_next       = nx;
    ny_next       = ny;
    oor_flag_next = oor_flag;

    case (stat.mode)
      MODE_ROW:   cmd.am = AM_ROW;
      MODE_COL:   cmd.am = AM_COL;
      MODE_QUERY: cmd.am = (state == S_EVAL) ? AM_POINT : AM_NEIGH;
      default:    cmd.am = AM_POINT;
    endcase
    cmd.k  = k;
    cmd.nx = nx;
    cmd.ny = ny;

    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          k_next     = '0;
          nx_next    = '0;
          ny_next    = '0;
          state_next = S_XDIV;
        end
      end
      S_XDIV: begin
        if (stat.div_done) begin
          cmd.cap_x  = 1'b1;
          state_next = S_YDIV;
        end
      end
      S_YDIV: begin
        if (stat.div_done) begin
          cmd.cap_y  = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        // row and column inserts check their first cell only
        if (!stat.en || (stat.mode > MODE_QUERY)) begin
          oor_flag_next = 1'b0;
          state_next    = S_OUT;
        end else if (!stat.addr_ok) begin
          oor_flag_next = 1'b1;
          state_next    = S_OUT;
        end else begin
          oor_flag_next = 1'b0;
          state_next    = S_RD;
        end
      end
      S_RD: begin
        if (stat.addr_ok) begin
          cmd.rd     = 1'b1;
          state_next = (stat.mode == MODE_QUERY) ? S_ACC : S_WR;
        end else if (stat.last) begin
          state_next = S_OUT;
        end else begin
          k_next  = 7'(k + 7'd1);
          nx_next = (nx == NB_LAST) ? 2'd0 : 2'(nx + 2'd1);
          ny_next = (nx == NB_LAST) ? 2'(ny + 2'd1) : ny;
        end
      end
      S_WR, S_ACC: begin
        cmd.wr  = (state == S_WR);
        cmd.acc = (state == S_ACC);
        if (stat.last) begin
          state_next = S_OUT;
        end else begin
          k_next     = 7'(k + 7'd1);
          nx_next    = (nx == NB_LAST) ? 2'd0 : 2'(nx + 2'd1);
          ny_next    = (nx == NB_LAST) ? 2'(ny + 2'd1) : ny;
          state_next = S_RD;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_oor  = oor_flag;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/cell_list_neighbor_grid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cell_list_neighbor_grid
// Uniform cell grid of actor occupancy bitmaps with point, row and column
// updates and 3x3 neighborhood queries.
// ----------------------------------------------------------------------------
// sequence: two serial divisions give the cell coordinates, then each cell takes a read and
//   a write or accumulate on the single memory port; cells off the grid are skipped. A
//   depart/arrive touches one cell, a wall insert a row or column, a query the 3x3 block
// throughput: one item in flight; the next is taken the cycle after the result loads,
//   a stalled result holds the input off
// reset: synchronous; then a sweep over all GRID_CELLS addresses zeroes the occupancy memory
module cell_list_neighbor_grid #(
  parameter int MAX_ACTORS = 64,
  parameter int GRID_CELLS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         mode,
  input  wire logic [5:0]         actor_id,
  input  wire logic signed [31:0] coord_x,
  input  wire logic signed [31:0] coord_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [63:0]             neighbor_mask,
  output logic                    out_of_range
);
  import clng_pkg::*;

  logic               map_en;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic [30:0]        cell_edge;
  logic [6:0]         grid_w;
  logic [6:0]         grid_h;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_en    <= 1'b0;
      origin_x  <= '0;
      origin_y  <= '0;
      cell_edge <= CELL_EDGE_RST;
      grid_w    <= DIM_MAX;
      grid_h    <= DIM_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAP_EN:    map_en    <= cfg_data[0];
        CFG_ORIGIN_X:  origin_x  <= cfg_data;
        CFG_ORIGIN_Y:  origin_y  <= cfg_data;
        CFG_CELL_EDGE: cell_edge <= cfg_data[30:0];
        CFG_GRID_W:    grid_w    <= cfg_data[6:0];
        CFG_GRID_H:    grid_h    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // dimensions clamped to one through the maximum
  always_comb begin
    cfg.map_en    = map_en;
    cfg.origin_x  = origin_x;
    cfg.origin_y  = origin_y;
    cfg.cell_edge = cell_edge;
    cfg.wdim      = (grid_w == '0) ? DIM_MIN : (grid_w > DIM_MAX) ? DIM_MAX : grid_w;
    cfg.hdim      = (grid_h == '0) ? DIM_MIN : (grid_h > DIM_MAX) ? DIM_MAX : grid_h;
  end

  clng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  clng_dp #(
    .MAX_ACTORS (MAX_ACTORS),
    .GRID_CELLS (GRID_CELLS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .actor_id      (actor_id),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .neighbor_mask (neighbor_mask),
    .out_of_range  (out_of_range)
  );

  a_disabled_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !map_en |-> (neighbor_mask == '0) && !out_of_range)
    else $error("item result not empty while mapping disabled");

  a_oor_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> neighbor_mask == '0)
    else $error("out-of-range item carries a neighbor mask");

  a_mask_width: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (neighbor_mask >> MAX_ACTORS) == '0)
    else $error("neighbor mask has bits above the actor count");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded while input side idle");

endmodule
`default_nettype wire
